@@ hw/rtl/seven_bit_channel_frame_decoder_core_macros.svh @@
// Assertion macros for the seven-bit channel frame decoder RTL.
`ifndef SEVEN_BIT_CHANNEL_FRAME_DECODER_CORE_MACROS_SVH
`define SEVEN_BIT_CHANNEL_FRAME_DECODER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SBCFD_ASSERT_SAME(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sbcfd assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SBCFD_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sbcfd assertion failed");

`endif

@@ hw/rtl/sbcfd_pkg.sv @@
// Types and constants for the seven-bit channel frame decoder.
package sbcfd_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned PIECE_W   = 7;
    localparam int unsigned CHANNEL_W = 4;
    localparam int unsigned VALUE_W   = 32;
    localparam int unsigned HELD_W    = 3;
    localparam int unsigned PIECES    = 5;
    localparam int unsigned PIECE_IDX_W = 3;

    // Header byte ranges.
    localparam logic [BYTE_W-1:0] SHORT_HDR_MIN = 8'd192;
    localparam logic [BYTE_W-1:0] LONG_HDR_MIN  = 8'd128;
    localparam logic [BYTE_W-1:0] LONG_HDR_MAX  = 8'd191;

    // Index of the piece that completes each frame kind.
    localparam logic [HELD_W-1:0] SHORT_LAST = 3'd2;
    localparam logic [HELD_W-1:0] LONG_LAST  = 3'd4;

    typedef enum logic [1:0] {
        MODE_NONE  = 2'd0,
        MODE_SHORT = 2'd1,
        MODE_LONG  = 2'd2
    } frame_mode_t;

    // One decoded frame.
    typedef struct packed {
        logic [CHANNEL_W-1:0]      channel;
        logic signed [VALUE_W-1:0] value;
        logic                      is_long;
    } frame_result_t;

    // Framing state reported by the decoder.
    typedef struct packed {
        logic              frame_open;
        logic [HELD_W-1:0] bytes_held;
    } frame_status_t;

endpackage

@@ hw/rtl/sbcfd_in_stage.sv @@
// Input register holding one received byte until the decoder consumes it.
module sbcfd_in_stage (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          rx_valid,
    output logic                          rx_ready,
    input  logic [sbcfd_pkg::BYTE_W-1:0]  rx_byte,
    input  logic                          consume,
    output logic                          held_valid,
    output logic [sbcfd_pkg::BYTE_W-1:0]  held_byte
);
    import sbcfd_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    logic [BYTE_W-1:0] byte_reg;

    // The register frees up in the same cycle as its byte is consumed.
    assign rx_ready   = !valid_reg || consume;
    assign valid_next = (rx_valid && rx_ready) ? 1'b1 : (consume ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload capture on each accepted transaction.
    always_ff @(posedge clk)
    begin
        if (rx_valid && rx_ready)
        begin
            byte_reg <= rx_byte;
        end
    end

    assign held_valid = valid_reg;
    assign held_byte  = byte_reg;

endmodule

@@ hw/rtl/sbcfd_decode.sv @@
// Framing state machine and value assembly for one byte per cycle, taking a byte only on step.
module sbcfd_decode (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  logic [sbcfd_pkg::BYTE_W-1:0]  in_byte,
    output logic                          res_valid,
    output sbcfd_pkg::frame_result_t      res,
    output sbcfd_pkg::frame_status_t      status
);
    import sbcfd_pkg::*;

    frame_mode_t          mode_reg;
    frame_mode_t          mode_next;
    logic [HELD_W-1:0]    held_reg;
    logic [HELD_W-1:0]    held_next;
    logic [CHANNEL_W-1:0] channel_reg;
    logic [CHANNEL_W-1:0] channel_next;
    logic [PIECE_W-1:0]   pieces_reg [PIECES];

    logic                 is_short_hdr;
    logic                 is_long_hdr;
    logic                 is_bad_hdr;
    logic                 is_data;
    logic                 piece_write;
    logic [PIECE_IDX_W-1:0] piece_idx;
    logic [PIECE_W-1:0]   piece_data;
    logic [15:0]          short_bits;

    // Byte classification.
    always_comb
    begin
        is_short_hdr = in_byte inside {[SHORT_HDR_MIN:8'd255]};
        is_long_hdr  = (in_byte inside {[LONG_HDR_MIN:LONG_HDR_MAX]}) && (in_byte[1:0] == 2'b00);
        is_bad_hdr   = (in_byte inside {[LONG_HDR_MIN:LONG_HDR_MAX]}) && (in_byte[1:0] != 2'b00);
        is_data      = !in_byte[BYTE_W-1];
    end

    // Next state of the framing machine.
    always_comb
    begin
        mode_next    = mode_reg;
        held_next    = held_reg;
        channel_next = channel_reg;
        if (step)
        begin
            if (is_short_hdr)
            begin
                mode_next    = MODE_SHORT;
                held_next    = 3'd1;
                channel_next = in_byte[5:2];
            end
            else if (is_long_hdr)
            begin
                mode_next    = MODE_LONG;
                held_next    = '0;
                channel_next = in_byte[5:2];
            end
            else if (is_bad_hdr)
            begin
                mode_next = MODE_NONE;
                held_next = '0;
            end
            else
            begin
                case (mode_reg)
                    MODE_SHORT:
                    begin
                        if (held_reg >= SHORT_LAST)
                        begin
                            mode_next = MODE_NONE;
                            held_next = '0;
                        end
                        else
                        begin
                            held_next = held_reg + 3'd1;
                        end
                    end
                    MODE_LONG:
                    begin
                        if (held_reg >= LONG_LAST)
                        begin
                            mode_next = MODE_NONE;
                            held_next = '0;
                        end
                        else
                        begin
                            held_next = held_reg + 3'd1;
                        end
                    end
                    default:
                    begin
                        mode_next = MODE_NONE;
                        held_next = '0;
                    end
                endcase
            end
        end
    end

    // Piece store write port: header low bits or a data byte.
    always_comb
    begin
        piece_write = 1'b0;
        piece_idx   = held_reg;
        piece_data  = in_byte[PIECE_W-1:0];
        if (step && is_short_hdr)
        begin
            piece_write = 1'b1;
            piece_idx   = '0;
            piece_data  = {5'd0, in_byte[1:0]};
        end
        else if (step && is_data && (mode_reg != MODE_NONE) && (held_reg < LONG_LAST))
        begin
            piece_write = 1'b1;
        end
    end

    // Outputs: a frame completes on its final data byte.
    always_comb
    begin
        res_valid   = 1'b0;
        short_bits  = {in_byte[PIECE_W-1:0], pieces_reg[1], pieces_reg[0][1:0]};
        res.channel = channel_reg;
        res.is_long = 1'b0;
        res.value   = {{16{short_bits[15]}}, short_bits};
        case (mode_reg)
            MODE_SHORT:
            begin
                res_valid = step && is_data && (held_reg == SHORT_LAST);
            end
            MODE_LONG:
            begin
                res_valid   = step && is_data && (held_reg == LONG_LAST);
                res.is_long = 1'b1;
                res.value   = {in_byte[3:0], pieces_reg[3], pieces_reg[2],
                               pieces_reg[1], pieces_reg[0]};
            end
            default:
            begin
                res_valid = 1'b0;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_NONE;
            held_reg    <= '0;
            channel_reg <= '0;
        end
        else
        begin
            mode_reg    <= mode_next;
            held_reg    <= held_next;
            channel_reg <= channel_next;
        end
    end

    // Piece store, no reset: a frame only reads pieces it wrote itself.
    always_ff @(posedge clk)
    begin
        if (piece_write)
        begin
            pieces_reg[piece_idx] <= piece_data;
        end
    end

    assign status.frame_open = (mode_reg != MODE_NONE);
    assign status.bytes_held = held_reg;

endmodule

@@ hw/rtl/sbcfd_out_stage.sv @@
// Result register driving the output channel.
module sbcfd_out_stage (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      load,
    input  sbcfd_pkg::frame_result_t  res,
    output logic                      space,
    output logic                      frame_valid,
    input  logic                      frame_ready,
    output sbcfd_pkg::frame_result_t  res_out
);
    import sbcfd_pkg::*;

    logic          valid_reg;
    logic          valid_next;
    frame_result_t res_reg;

    // Room for a new result when empty or when the waiting one leaves now.
    assign space      = !valid_reg || frame_ready;
    assign valid_next = load ? 1'b1 : (frame_ready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign frame_valid = valid_reg;
    assign res_out     = res_reg;

endmodule

@@ hw/rtl/seven_bit_channel_frame_decoder_core.sv @@
// The input register holds each accepted byte and the output register holds each completed result.
// Throughput: one byte per cycle unless a held result stalls, set by the combinational decode between the registers.
// A held result stalls further bytes only while the output side is not ready.
// Reset (rst_n, asynchronous, active low) closes any open frame and empties both registers.
// Top level of the seven-bit channel frame decoder.
`include "seven_bit_channel_frame_decoder_core_macros.svh"

module seven_bit_channel_frame_decoder_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 rx_valid,
    output logic                                 rx_ready,
    input  logic [sbcfd_pkg::BYTE_W-1:0]         rx_byte,
    output logic                                 frame_valid,
    input  logic                                 frame_ready,
    output logic [sbcfd_pkg::CHANNEL_W-1:0]      frame_channel,
    output logic signed [sbcfd_pkg::VALUE_W-1:0] frame_value,
    output logic                                 is_long_frame
);
    import sbcfd_pkg::*;

    logic              held_valid;
    logic [BYTE_W-1:0] held_byte;
    logic              out_space;
    logic              step;
    logic              res_valid;
    frame_result_t     res;
    frame_result_t     res_out;
    frame_status_t     status;

    // A byte is decoded once the result register can take whatever it yields.
    assign step = held_valid && out_space;

    sbcfd_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx_valid   (rx_valid),
        .rx_ready   (rx_ready),
        .rx_byte    (rx_byte),
        .consume    (step),
        .held_valid (held_valid),
        .held_byte  (held_byte)
    );

    sbcfd_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .in_byte   (held_byte),
        .res_valid (res_valid),
        .res       (res),
        .status    (status)
    );

    sbcfd_out_stage u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (res_valid),
        .res         (res),
        .space       (out_space),
        .frame_valid (frame_valid),
        .frame_ready (frame_ready),
        .res_out     (res_out)
    );

    assign frame_channel = res_out.channel;
    assign frame_value   = res_out.value;
    assign is_long_frame = res_out.is_long;

    // A completed frame always closes.
    `SBCFD_ASSERT_NEXT(a_frame_closes, res_valid, !status.frame_open && (status.bytes_held == '0))
    // The piece count never runs past the last piece of a long frame.
    `SBCFD_ASSERT_SAME(a_held_bound, 1'b1, status.bytes_held <= LONG_LAST)
    // A new result is never loaded over one that has not been taken.
    `SBCFD_ASSERT_SAME(a_no_overwrite, res_valid, !frame_valid || frame_ready)
    // A held byte that is not decoded blocks the input.
    `SBCFD_ASSERT_SAME(a_input_blocked, held_valid && !step, !rx_ready)

endmodule
